>>> rtl/core/heightmap_triangle_emitter_defines.svh
// Assertion macros shared by the heightmap triangle emitter RTL.
// Each macro expects clk and rst_n to be visible in the calling module.
`ifndef HEIGHTMAP_TRIANGLE_EMITTER_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_EMITTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hte_pkg.sv
// Shared constants and types for the heightmap triangle emitter.
// No dependencies; imported by every module of the block.
package hte_pkg;

    localparam int MAX_ROWS_DEF    = 4096;
    localparam int HEIGHT_BITS_DEF = 24;
    localparam int COL_BITS_DEF    = 16;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 13'd4096;

    localparam int ROW_OUT_W   = 12;
    localparam int NQUAD       = 4;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        QUAD_XM_YM = 2'd0,
        QUAD_XM_YP = 2'd1,
        QUAD_XP_YP = 2'd2,
        QUAD_XP_YM = 2'd3
    } quad_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/core/hte_front.sv
// Front end: accepts samples, tracks row and column, holds the two column banks
// and classifies each finished center into a quadrant mask. Depends on hte_pkg.
module hte_front #(
    parameter int MAX_ROWS    = hte_pkg::MAX_ROWS_DEF,
    parameter int HEIGHT_BITS = hte_pkg::HEIGHT_BITS_DEF,
    parameter int COL_BITS    = hte_pkg::COL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [hte_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic                          in_height_valid,
    input  logic [HEIGHT_BITS-1:0]        in_height,
    input  hte_pkg::qstat_t               job_stat,
    output logic                          job_push,
    output logic [COL_BITS+$clog2(MAX_ROWS)+5*HEIGHT_BITS+hte_pkg::NQUAD-1:0] job_data
);
    import hte_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W = HEIGHT_BITS + 1;

    logic [CFG_W-1:0]    row_count_reg;
    logic [CNT_W-1:0]    active_rows;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;
    logic [CNT_W-1:0]    row_inc;
    logic                row_wrap;
    logic                accept;
    logic                flush;
    logic                cur_valid;
    logic [ROW_W-1:0]    addr_b;
    logic [ENT_W-1:0]    wr_entry;

    logic [ENT_W-1:0]    bank0_mem [MAX_ROWS];
    logic [ENT_W-1:0]    bank1_mem [MAX_ROWS];
    logic [ENT_W-1:0]    b0_a_reg;
    logic [ENT_W-1:0]    b0_b_reg;
    logic [ENT_W-1:0]    b1_a_reg;
    logic [ENT_W-1:0]    b1_b_reg;

    logic                s1_valid_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    logic [ENT_W-1:0]    s1_cur_reg;
    logic                s1_col_ge1_reg;
    logic                s1_col_ge2_reg;
    logic                s1_row_ge1_reg;
    logic                s1_yp_in_reg;
    logic [ENT_W-1:0]    lastc_reg;

    logic [ENT_W-1:0]    center;
    logic [ENT_W-1:0]    older;
    logic [ENT_W-1:0]    yplus;
    logic                has_c;
    logic                has_xm;
    logic                has_xp;
    logic                has_ym;
    logic                has_yp;
    logic [NQUAD-1:0]    mask;
    logic                s1_go;
    logic [COL_BITS-1:0] center_col;

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            active_rows = CNT_W'(1);
        end
        else if (CMP_W'(row_count_reg) > CMP_W'(MAX_ROWS))
        begin
            active_rows = CNT_W'(MAX_ROWS);
        end
        else
        begin
            active_rows = CNT_W'(row_count_reg);
        end
    end

    assign accept    = in_valid && in_ready;
    assign flush     = (kind_t'(in_kind) == KIND_FLUSH);
    assign cur_valid = !flush && in_height_valid;
    assign row_inc   = CNT_W'(row_reg) + CNT_W'(1);
    assign row_wrap  = (row_inc >= active_rows);
    assign addr_b    = row_reg + ROW_W'(1);
    assign wr_entry  = {cur_valid, in_height};

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_valid)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (row_wrap)
            begin
                row_next = '0;
                col_next = flush ? '0 : col_reg + COL_BITS'(1);
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                row_count_reg <= cfg_data;
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Even columns live in bank 0, odd columns in bank 1; the write lands on
    // the column two back, which is read out in the same cycle before it goes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!col_reg[0])
            begin
                bank0_mem[row_reg] <= wr_entry;
            end
            b0_a_reg <= bank0_mem[row_reg];
            b0_b_reg <= bank0_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (col_reg[0])
            begin
                bank1_mem[row_reg] <= wr_entry;
            end
            b1_a_reg <= bank1_mem[row_reg];
            b1_b_reg <= bank1_mem[addr_b];
        end
    end

    assign center = s1_col_reg[0] ? b0_a_reg : b1_a_reg;
    assign older  = s1_col_reg[0] ? b1_a_reg : b0_a_reg;
    assign yplus  = s1_col_reg[0] ? b0_b_reg : b1_b_reg;

    assign has_c  = s1_col_ge1_reg && center[ENT_W-1];
    assign has_xm = s1_col_ge2_reg && older[ENT_W-1];
    assign has_xp = s1_cur_reg[ENT_W-1];
    assign has_ym = s1_row_ge1_reg && lastc_reg[ENT_W-1];
    assign has_yp = s1_yp_in_reg && yplus[ENT_W-1];

    always_comb
    begin
        mask             = '0;
        mask[QUAD_XM_YM] = has_c && has_xm && has_ym;
        mask[QUAD_XM_YP] = has_c && has_xm && has_yp;
        mask[QUAD_XP_YP] = has_c && has_xp && has_yp;
        mask[QUAD_XP_YM] = has_c && has_xp && has_ym;
    end

    assign s1_go    = !s1_valid_reg || (mask == '0) || !job_stat.full;
    assign in_ready = s1_go;
    assign job_push = s1_valid_reg && (mask != '0) && !job_stat.full;

    assign center_col = s1_col_reg - COL_BITS'(1);
    assign job_data   = {mask,
                         s1_cur_reg[HEIGHT_BITS-1:0],
                         yplus[HEIGHT_BITS-1:0],
                         lastc_reg[HEIGHT_BITS-1:0],
                         older[HEIGHT_BITS-1:0],
                         center[HEIGHT_BITS-1:0],
                         s1_row_reg,
                         center_col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg     <= row_reg;
            s1_col_reg     <= col_reg;
            s1_cur_reg     <= wr_entry;
            s1_col_ge1_reg <= (col_reg != '0);
            s1_col_ge2_reg <= (col_reg > COL_BITS'(1));
            s1_row_ge1_reg <= (row_reg != '0);
            s1_yp_in_reg   <= !row_wrap;
        end
        // hold the center of the row just finished; it is the next row's y- neighbor
        if (s1_valid_reg && s1_go)
        begin
            lastc_reg <= center;
        end
    end

endmodule

>>> rtl/core/hte_queue.sv
// Small register queue of classified centers between front and back end.
// Depends on hte_pkg and heightmap_triangle_emitter_defines.svh.
`include "heightmap_triangle_emitter_defines.svh"

module hte_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hte_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output hte_pkg::qstat_t    stat
);
    import hte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HTE_ASSERT_NOW(a_no_overflow, push, !stat.full, "queue push while full")
    `HTE_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "queue pop while empty")
    `HTE_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

>>> rtl/core/hte_back.sv
// Back end: walks the quadrant mask of the queue head and, unless the output stalls,
// forms one triangle per cycle with its normal in the output register. Depends on hte_pkg.
`include "heightmap_triangle_emitter_defines.svh"

module hte_back #(
    parameter int MAX_ROWS    = hte_pkg::MAX_ROWS_DEF,
    parameter int HEIGHT_BITS = hte_pkg::HEIGHT_BITS_DEF,
    parameter int COL_BITS    = hte_pkg::COL_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hte_pkg::qstat_t        job_stat,
    input  logic [COL_BITS+$clog2(MAX_ROWS)+5*HEIGHT_BITS+hte_pkg::NQUAD-1:0] job_data,
    output logic                   job_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((COL_BITS+hte_pkg::ROW_OUT_W+5*HEIGHT_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import hte_pkg::*;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int HB       = HEIGHT_BITS;
    localparam int OFS_ROW  = COL_BITS;
    localparam int OFS_ZC   = OFS_ROW + ROW_W;
    localparam int OFS_ZXM  = OFS_ZC + HB;
    localparam int OFS_ZYM  = OFS_ZXM + HB;
    localparam int OFS_ZYP  = OFS_ZYM + HB;
    localparam int OFS_ZXP  = OFS_ZYP + HB;
    localparam int OFS_MASK = OFS_ZXP + HB;
    localparam int DATA_W   = ((COL_BITS + ROW_OUT_W + 5 * HB + 2 + 7) / 8) * 8;

    logic [COL_BITS-1:0]  job_col;
    logic [ROW_W-1:0]     job_row;
    logic [HB-1:0]        job_zc;
    logic [HB-1:0]        job_zxm;
    logic [HB-1:0]        job_zym;
    logic [HB-1:0]        job_zyp;
    logic [HB-1:0]        job_zxp;
    logic [NQUAD-1:0]     job_mask;

    logic [NQUAD-1:0]     done_reg;
    logic [NQUAD-1:0]     done_next;
    logic [NQUAD-1:0]     rem;
    logic [NQUAD-1:0]     sel_bit;
    logic [NQUAD-1:0]     rem_after;
    quad_t                sel;
    logic                 load;
    logic                 last_w;
    logic [HB-1:0]        side_w;
    logic [HB-1:0]        end_w;
    logic                 dx_neg;
    logic                 dy_neg;
    logic [HB:0]          nx_w;
    logic [HB:0]          ny_w;

    logic                 out_valid_reg;
    logic [COL_BITS-1:0]  out_col_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    quad_t                out_quad_reg;
    logic [HB-1:0]        out_zc_reg;
    logic [HB-1:0]        out_side_reg;
    logic [HB-1:0]        out_end_reg;
    logic [HB:0]          out_nx_reg;
    logic [HB:0]          out_ny_reg;
    logic                 out_last_reg;

    assign job_col  = job_data[OFS_ROW-1:0];
    assign job_row  = job_data[OFS_ZC-1:OFS_ROW];
    assign job_zc   = job_data[OFS_ZXM-1:OFS_ZC];
    assign job_zxm  = job_data[OFS_ZYM-1:OFS_ZXM];
    assign job_zym  = job_data[OFS_ZYP-1:OFS_ZYM];
    assign job_zyp  = job_data[OFS_ZXP-1:OFS_ZYP];
    assign job_zxp  = job_data[OFS_MASK-1:OFS_ZXP];
    assign job_mask = job_data[OFS_MASK+NQUAD-1:OFS_MASK];

    assign rem = job_mask & ~done_reg;

    always_comb
    begin
        if (rem[QUAD_XM_YM])
        begin
            sel = QUAD_XM_YM;
        end
        else if (rem[QUAD_XM_YP])
        begin
            sel = QUAD_XM_YP;
        end
        else if (rem[QUAD_XP_YP])
        begin
            sel = QUAD_XP_YP;
        end
        else
        begin
            sel = QUAD_XP_YM;
        end
    end

    assign sel_bit   = NQUAD'(1) << sel;
    assign rem_after = rem & ~sel_bit;
    assign last_w    = (rem_after == '0);
    assign load      = !job_stat.empty && (!out_valid_reg || m_tready);
    assign job_pop   = load && last_w;

    always_comb
    begin
        done_next = done_reg;
        if (load)
        begin
            done_next = last_w ? '0 : (done_reg | sel_bit);
        end
    end

    always_comb
    begin
        case (sel)
            QUAD_XM_YM:
            begin
                side_w = job_zxm;
                end_w  = job_zym;
                dx_neg = 1'b1;
                dy_neg = 1'b1;
            end
            QUAD_XM_YP:
            begin
                side_w = job_zxm;
                end_w  = job_zyp;
                dx_neg = 1'b1;
                dy_neg = 1'b0;
            end
            QUAD_XP_YP:
            begin
                side_w = job_zxp;
                end_w  = job_zyp;
                dx_neg = 1'b0;
                dy_neg = 1'b0;
            end
            QUAD_XP_YM:
            begin
                side_w = job_zxp;
                end_w  = job_zym;
                dx_neg = 1'b0;
                dy_neg = 1'b1;
            end
            default:
            begin
                side_w = job_zxm;
                end_w  = job_zym;
                dx_neg = 1'b1;
                dy_neg = 1'b1;
            end
        endcase
    end

    // normal = -step * delta, folded into the operand order of one subtract
    always_comb
    begin
        if (dx_neg)
        begin
            nx_w = {side_w[HB-1], side_w} - {job_zc[HB-1], job_zc};
        end
        else
        begin
            nx_w = {job_zc[HB-1], job_zc} - {side_w[HB-1], side_w};
        end
        if (dy_neg)
        begin
            ny_w = {end_w[HB-1], end_w} - {job_zc[HB-1], job_zc};
        end
        else
        begin
            ny_w = {job_zc[HB-1], job_zc} - {end_w[HB-1], end_w};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_col_reg  <= job_col;
            out_row_reg  <= ROW_OUT_W'(job_row);
            out_quad_reg <= sel;
            out_zc_reg   <= job_zc;
            out_side_reg <= side_w;
            out_end_reg  <= end_w;
            out_nx_reg   <= nx_w;
            out_ny_reg   <= ny_w;
            out_last_reg <= last_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_quad_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = DATA_W'({out_ny_reg, out_nx_reg, out_end_reg, out_side_reg,
                               out_zc_reg, out_row_reg, out_col_reg});

    `HTE_ASSERT_NOW(a_job_has_tri, !job_stat.empty, job_mask != '0, "queued center without triangles")
    `HTE_ASSERT_NOW(a_rem_nonempty, !job_stat.empty, rem != '0, "head emitted past its mask")
    `HTE_ASSERT_NEXT(a_head_held, load && !last_w, !job_stat.empty && (done_reg != '0), "head lost before its last triangle")

endmodule

>>> rtl/core/heightmap_triangle_emitter.sv
// A sample's first triangle passes the front stage registers, the job queue and the
// output register. Throughput: one sample per cycle into the column banks and
// classifier while the queue is not full; the emitter sends one triangle per cycle
// while the output is not stalled, up to four per sample, buffered by a four-entry queue.
// Reset: asynchronous, clears counters and handshake state, row_count to 4096;
// the column banks are not cleared and need no clearing pass.
module heightmap_triangle_emitter #(
    parameter int MAX_ROWS    = hte_pkg::MAX_ROWS_DEF,
    parameter int HEIGHT_BITS = hte_pkg::HEIGHT_BITS_DEF,
    parameter int COL_BITS    = hte_pkg::COL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hte_pkg::CFG_W-1:0]     cfg_data,   // row_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0] s_tdata, // height
    input  logic [1:0]                    s_tuser,    // kind, height_valid
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // center_col, center_row, center_height, side_height, end_height, facet_nx, facet_ny
    output logic [((COL_BITS+hte_pkg::ROW_OUT_W+5*HEIGHT_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                    m_tuser,    // quadrant
    output logic                          m_tlast
);
    import hte_pkg::*;

    localparam int JOB_W = COL_BITS + $clog2(MAX_ROWS) + 5 * HEIGHT_BITS + NQUAD;

    logic             job_push;
    logic             job_pop;
    logic [JOB_W-1:0] push_data;
    logic [JOB_W-1:0] head_data;
    qstat_t           job_stat;

    assign cfg_ready = 1'b1;

    hte_front #(
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS),
        .COL_BITS    (COL_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_kind         (s_tuser[0]),
        .in_height_valid (s_tuser[1]),
        .in_height       (s_tdata[HEIGHT_BITS-1:0]),
        .job_stat        (job_stat),
        .job_push        (job_push),
        .job_data        (push_data)
    );

    hte_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_data),
        .pop       (job_pop),
        .pop_data  (head_data),
        .stat      (job_stat)
    );

    hte_back #(
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS),
        .COL_BITS    (COL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_stat (job_stat),
        .job_data (head_data),
        .job_pop  (job_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for heightmap_triangle_emitter: stream driver, output monitor,
// in-bench triangle predictor and per-field scoreboard over several pacing modes.
// Depends on hte_pkg and the heightmap_triangle_emitter RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hte_pkg::*;

    localparam int DATA_IN_W     = ((HEIGHT_BITS_DEF + 7) / 8) * 8;
    localparam int DATA_OUT_W    =
        ((COL_BITS_DEF + ROW_OUT_W + 5 * HEIGHT_BITS_DEF + 2 + 7) / 8) * 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_CAP    = 50;

    typedef logic signed [HEIGHT_BITS_DEF-1:0] height_t;
    typedef logic signed [HEIGHT_BITS_DEF:0]   slope_t;

    typedef struct {
        kind_t   kind;
        height_t height;
        logic    present;
    } sample_t;

    typedef struct {
        logic [COL_BITS_DEF-1:0] col;
        logic [ROW_OUT_W-1:0]    row;
        quad_t                   quad;
        height_t                 zc;
        height_t                 zs;
        height_t                 ze;
        slope_t                  nx;
        slope_t                  ny;
        logic                    last;
    } triangle_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata   = '0;   // height
    logic [1:0]            s_tuser   = '0;   // kind, height_valid
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;          // center_col, center_row, center_height,
                                             // side_height, end_height, facet_nx, facet_ny
    logic [1:0]            m_tuser;          // quadrant
    logic                  m_tlast;

    sample_t   pending_samples[$];
    triangle_t expected_tris[$];

    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;
    bit hold_request    = 1'b0;
    bit hold_taken      = 1'b0;
    int hold_left       = 0;
    bit in_taken        = 1'b0;
    int quiet_cycles    = 0;
    int mismatch_count  = 0;
    int samples_taken   = 0;
    int tris_checked    = 0;
    int cfg_writes      = 0;

    height_t             prev_h [MAX_ROWS_DEF];
    bit                  prev_v [MAX_ROWS_DEF];
    height_t             old_h  [MAX_ROWS_DEF];
    bit                  old_v  [MAX_ROWS_DEF];
    logic [COL_BITS_DEF-1:0] col_idx       = '0;
    int                  row_idx       = 0;
    logic [CFG_W-1:0]    row_count_reg = ROW_COUNT_RESET;

    heightmap_triangle_emitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string where, input string name,
                                 input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s %s got %h want %h", where, name, got, want));
        end
    endtask

    function automatic triangle_t make_triangle(input logic [COL_BITS_DEF-1:0] col,
                                                input int row, input quad_t quad,
                                                input height_t zc, input height_t zs,
                                                input height_t ze, input bit x_up,
                                                input bit y_up);
        triangle_t t;
        slope_t    dzl;
        slope_t    dzr;
        dzl    = zs - zc;
        dzr    = ze - zc;
        t.col  = col;
        t.row  = row[ROW_OUT_W-1:0];
        t.quad = quad;
        t.zc   = zc;
        t.zs   = zs;
        t.ze   = ze;
        t.nx   = x_up ? -dzl : dzl;
        t.ny   = y_up ? -dzr : dzr;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void predict_sample(input sample_t s);
        int        rows;
        int        r;
        bit        cur_v;
        bit        xm;
        bit        xp;
        bit        ym;
        bit        yp;
        height_t   zc;
        height_t   zxm;
        height_t   zym;
        height_t   zyp;
        triangle_t found[$];
        if (row_count_reg == 0)
            rows = 1;
        else if (row_count_reg > MAX_ROWS_DEF)
            rows = MAX_ROWS_DEF;
        else
            rows = int'(row_count_reg);
        r     = (row_idx >= rows) ? 0 : row_idx;
        cur_v = (s.kind == KIND_SAMPLE) && s.present;
        if (col_idx >= 1 && prev_v[r])
        begin
            zc  = prev_h[r];
            zxm = old_h[r];
            xm  = (col_idx >= 2) && old_v[r];
            xp  = cur_v;
            ym  = (r >= 1) ? old_v[r-1] : 1'b0;
            zym = (r >= 1) ? old_h[r-1] : '0;
            yp  = (r + 1 < rows) ? prev_v[r+1] : 1'b0;
            zyp = (r + 1 < rows) ? prev_h[r+1] : '0;
            if (xm && ym)
                found.push_back(make_triangle(col_idx - 1'b1, r, QUAD_XM_YM,
                                              zc, zxm, zym, 1'b0, 1'b0));
            if (xm && yp)
                found.push_back(make_triangle(col_idx - 1'b1, r, QUAD_XM_YP,
                                              zc, zxm, zyp, 1'b0, 1'b1));
            if (xp && yp)
                found.push_back(make_triangle(col_idx - 1'b1, r, QUAD_XP_YP,
                                              zc, s.height, zyp, 1'b1, 1'b1));
            if (xp && ym)
                found.push_back(make_triangle(col_idx - 1'b1, r, QUAD_XP_YM,
                                              zc, s.height, zym, 1'b1, 1'b0));
            if (found.size() > 0)
                found[found.size()-1].last = 1'b1;
            foreach (found[i])
                expected_tris.push_back(found[i]);
        end
        old_h[r]  = prev_h[r];
        old_v[r]  = prev_v[r];
        prev_h[r] = cur_v ? s.height : '0;
        prev_v[r] = cur_v;
        r++;
        if (r >= rows)
        begin
            r       = 0;
            col_idx = (s.kind == KIND_FLUSH) ? '0 : col_idx + 1'b1;
        end
        row_idx = r;
    endfunction

    task automatic check_triangle();
        triangle_t got;
        triangle_t want;
        string     where;
        got.col  = m_tdata[15:0];
        got.row  = m_tdata[27:16];
        got.zc   = m_tdata[51:28];
        got.zs   = m_tdata[75:52];
        got.ze   = m_tdata[99:76];
        got.nx   = m_tdata[124:100];
        got.ny   = m_tdata[149:125];
        got.quad = quad_t'(m_tuser);
        got.last = m_tlast;
        if (expected_tris.size() == 0)
        begin
            report_mismatch($sformatf("unexpected triangle col %0d row %0d quadrant %0d",
                                      got.col, got.row, got.quad));
        end
        else
        begin
            want  = expected_tris.pop_front();
            where = $sformatf("col %0d row %0d quadrant %0d", want.col, want.row, want.quad);
            compare_field(where, "center_col", got.col, want.col);
            compare_field(where, "center_row", got.row, want.row);
            compare_field(where, "quadrant", got.quad, want.quad);
            compare_field(where, "center_height", got.zc, want.zc);
            compare_field(where, "side_height", got.zs, want.zs);
            compare_field(where, "end_height", got.ze, want.ze);
            compare_field(where, "facet_nx", got.nx, want.nx);
            compare_field(where, "facet_ny", got.ny, want.ny);
            compare_field(where, "last", got.last, want.last);
        end
        tris_checked++;
    endtask

    // Sample every handshake at the rising edge.
    always @(posedge clk)
    begin : monitor_proc
        sample_t s;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                row_count_reg = cfg_data;
                col_idx       = '0;
                row_idx       = 0;
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                s.kind    = kind_t'(s_tuser[0]);
                s.present = s_tuser[1];
                s.height  = s_tdata[HEIGHT_BITS_DEF-1:0];
                predict_sample(s);
                samples_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                check_triangle();
            end
        end
    end

    // Hold the current transaction until taken, then advance or idle.
    always @(negedge clk)
    begin : driver_proc
        sample_t s;
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= DATA_IN_W'(s.height);
                s_tuser  <= {s.present, s.kind};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver_proc
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("heightmap_triangle_emitter verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic height_t rand_height();
        case ($urandom_range(3))
            0: return height_t'(int'($urandom_range(1023)) - 512);
            1: return $urandom_range(1) ? height_t'({1'b0, {23{1'b1}}}) : height_t'({1'b1, 23'd0});
            default: return height_t'($urandom);
        endcase
    endfunction

    function automatic void queue_sample(input kind_t kind, input height_t height,
                                         input logic present);
        sample_t s;
        s.kind    = kind;
        s.height  = height;
        s.present = present;
        pending_samples.push_back(s);
    endfunction

    // Columns of samples with some holes and stray flush steps, then a flush column.
    function automatic void queue_frame(input int rows, input int cols, input int hole_pct,
                                        input int noise_pct);
        for (int c = 0; c < cols; c++)
        begin
            for (int r = 0; r < rows; r++)
            begin
                if ($urandom_range(99) < noise_pct)
                    queue_sample(KIND_FLUSH, rand_height(), 1'($urandom_range(1)));
                else
                    queue_sample(KIND_SAMPLE, rand_height(), $urandom_range(99) >= hole_pct);
            end
        end
        for (int r = 0; r < rows; r++)
            queue_sample(KIND_FLUSH, rand_height(), 1'($urandom_range(1)));
    endfunction

    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid || expected_tris.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_pacing(input int idle_pct, input int stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset row count: a few samples of the first column.
        set_pacing(0, 0);
        for (int i = 0; i < 4; i++)
            queue_sample(KIND_SAMPLE, rand_height(), $urandom_range(9) != 0);
        settle();

        write_row_count(13'd3);
        queue_sample(KIND_SAMPLE, 24'sh7FFFFF, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh800000, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh000000, 1'b0);
        queue_sample(KIND_SAMPLE, 24'sh800000, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh7FFFFF, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh000100, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh7FFFFF, 1'b1);
        queue_sample(KIND_FLUSH, 24'sh555555, 1'b1);
        queue_sample(KIND_SAMPLE, 24'shFFFFFF, 1'b1);
        queue_sample(KIND_FLUSH, 24'sh123456, 1'b1);
        queue_sample(KIND_FLUSH, 24'shABCDEF, 1'b0);
        queue_sample(KIND_FLUSH, 24'sh7FFFFF, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh000001, 1'b1);
        queue_sample(KIND_SAMPLE, 24'shFFFFFF, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh800000, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh7FFFFF, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh000000, 1'b1);
        queue_sample(KIND_SAMPLE, 24'sh000002, 1'b1);
        settle();

        write_row_count(13'd4);
        queue_frame(4, 3, 15, 3);
        settle();

        set_pacing(84, 0);
        write_row_count(13'd3);
        queue_frame(3, 4, 20, 3);
        settle();

        set_pacing(0, 84);
        write_row_count(13'd5);
        queue_frame(5, 3, 15, 3);
        settle();

        // Stall the output long enough to back up the input.
        set_pacing(0, 0);
        write_row_count(13'd6);
        hold_request = 1'b1;
        queue_frame(6, 4, 10, 0);
        settle();

        set_pacing(30, 30);
        write_row_count(13'd2);
        queue_frame(2, 5, 20, 5);
        settle();

        write_row_count(13'd0);
        queue_frame(1, 6, 20, 5);
        settle();

        set_pacing(0, 0);
        write_row_count(13'h1FFF);
        for (int i = 0; i < 6; i++)
            queue_sample(KIND_SAMPLE, rand_height(), 1'($urandom_range(1)));
        settle();

        set_pacing(30, 30);
        write_row_count(13'd7);
        queue_frame(7, 3, 15, 3);
        settle();

        set_pacing(0, 0);
        write_row_count(13'd2);
        queue_frame(2, 4, 40, 10);
        settle();

        $display("Run covered %0d input transactions, %0d triangles, %0d row_count writes.",
                 samples_taken, tris_checked, cfg_writes);
        $display("Row counts from zero to all ones, holes, flush steps, four pacing modes, "
                 , "one long output hold-off.");
        if (mismatch_count == 0 && expected_tris.size() == 0)
        begin
            $display("heightmap_triangle_emitter verification clean");
        end
        else
        begin
            $display("heightmap_triangle_emitter verification failed");
        end
        $finish;
    end

endmodule
